// File: hdl/fjdm_pkg.sv
`default_nettype none

package fjdm_pkg;

    // field widths of the channels
    localparam int FIELD_W      = 20;
    localparam int WEIGHT_W     = 16;
    localparam int TRIALS_W     = 16;
    localparam int OUT_TRIALS_W = 17;
    localparam int MASS_W       = 21;
    localparam int STATUS_W     = 2;

    // arithmetic widths, derived from the momentum width (CMP_W also from the mass width)
    localparam int MOMENTUM_BITS = 20;
    localparam int SUM_W         = MOMENTUM_BITS + 1;
    localparam int SQ_W          = 2 * SUM_W;
    localparam int M2_W          = SQ_W + 2;
    localparam int DIFF_W        = M2_W + 1;
    localparam int REM_W         = SUM_W + 3;
    localparam int ITER_W        = $clog2(SUM_W);
    localparam int CMP_W         = (SUM_W > MASS_W) ? SUM_W : MASS_W;

    // particle store and sequencer counters
    localparam int NPART  = 4;
    localparam int IDX_W  = $clog2(NPART);
    localparam int CNT_W  = 3;
    localparam int PAIR_W = 3;
    localparam int COMP_W = 3;

    localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(NPART);
    localparam logic [CNT_W-1:0]  CNT_SAT  = '1;
    localparam logic [MASS_W-1:0] MASS_MAX = '1;

    // pair slots: 01, 23, 02, 13, 03, 12
    localparam logic [PAIR_W-1:0] PAIR_FIRST_B = PAIR_W'(1);
    localparam logic [PAIR_W-1:0] PAIR_LAST    = PAIR_W'(5);

    // component steps of the square and accumulate sequence
    localparam logic [COMP_W-1:0] COMP_E    = COMP_W'(0);
    localparam logic [COMP_W-1:0] COMP_X    = COMP_W'(1);
    localparam logic [COMP_W-1:0] COMP_Y    = COMP_W'(2);
    localparam logic [COMP_W-1:0] COMP_Z    = COMP_W'(3);
    localparam logic [COMP_W-1:0] COMP_ACC0 = COMP_W'(2);
    localparam logic [COMP_W-1:0] COMP_LAST = COMP_W'(5);

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] STATUS_BAD_COUNT = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] STATUS_NEG_M2    = STATUS_W'(2);

    typedef struct packed {
        logic        [MOMENTUM_BITS-1:0] e;
        logic signed [MOMENTUM_BITS-1:0] px;
        logic signed [MOMENTUM_BITS-1:0] py;
        logic signed [MOMENTUM_BITS-1:0] pz;
    } part_t;

    // first particle of a pair slot
    function automatic logic [IDX_W-1:0] pair_first(input logic [PAIR_W-1:0] p);
        logic [IDX_W-1:0] r;
        case (p)
            PAIR_W'(1): r = IDX_W'(2);
            PAIR_W'(3): r = IDX_W'(1);
            PAIR_W'(5): r = IDX_W'(1);
            default:    r = IDX_W'(0);
        endcase
        return r;
    endfunction

    // second particle of a pair slot
    function automatic logic [IDX_W-1:0] pair_second(input logic [PAIR_W-1:0] p);
        logic [IDX_W-1:0] r;
        case (p)
            PAIR_W'(0): r = IDX_W'(1);
            PAIR_W'(2): r = IDX_W'(2);
            PAIR_W'(5): r = IDX_W'(2);
            default:    r = IDX_W'(3);
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/four_jet_dijet_mass_pairing.sv
// Four-jet dijet mass pairing.
// Input channel (in_valid / in_stall): one particle per transaction, energy and
// momentum in 10 MeV units; last_particle closes the event and carries its
// weight and trial count. A particle that is not last is taken without a stall.
// Output channel (out_valid / out_stall): one result per transaction. An event
// without exactly four particles gives one result (status 1), which passes from
// the result register to the output register. A four-particle event gives two
// results, the pair masses of the pairing with the closest mass squared, the
// first and then the second. The work is done by the shared squarer (six pairs,
// each read and then squared and accumulated component by component, plus a
// difference and compare per pairing) and by the bit-serial square root, one
// result bit per cycle. in_stall is high from the last particle until the final
// result of the event sits in the output register.
// A stalled result holds in the output register; the sequencer waits for it.
// Reset clears the particle count, the sequencer and the output valid; the
// particle store itself is not cleared.
`default_nettype none

module four_jet_dijet_mass_pairing
(
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     in_valid,
    output logic                                          in_stall,
    input  wire logic        [fjdm_pkg::FIELD_W-1:0]      energy,
    input  wire logic signed [fjdm_pkg::FIELD_W-1:0]      mom_x,
    input  wire logic signed [fjdm_pkg::FIELD_W-1:0]      mom_y,
    input  wire logic signed [fjdm_pkg::FIELD_W-1:0]      mom_z,
    input  wire logic signed [fjdm_pkg::WEIGHT_W-1:0]     event_weight,
    input  wire logic        [fjdm_pkg::TRIALS_W-1:0]     event_trials,
    input  wire logic                                     last_particle,
    output logic                                          out_valid,
    input  wire logic                                     out_stall,
    output logic             [fjdm_pkg::MASS_W-1:0]       pair_mass,
    output logic signed      [fjdm_pkg::WEIGHT_W-1:0]     out_weight,
    output logic             [fjdm_pkg::OUT_TRIALS_W-1:0] out_trials,
    output logic             [fjdm_pkg::STATUS_W-1:0]     status,
    output logic                                          last_result
);

    import fjdm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_SQ,
        ST_DIFF,
        ST_CMP,
        ST_ROOT_START,
        ST_ROOT,
        ST_EMIT
    } state_t;

    // particle store
    part_t            part_mem [NPART];
    part_t            rd_data_reg;
    part_t            wr_part;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;

    // sequencer and datapath registers
    state_t                     state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [PAIR_W-1:0]          pair_reg, pair_next;
    logic [COMP_W-1:0]          comp_reg, comp_next;
    part_t                      pa_reg, pa_next;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic [SQ_W-1:0]            sq_reg, sq_next;
    logic signed [M2_W-1:0]     acc_reg, acc_next;
    logic signed [M2_W-1:0]     a_reg, a_next;
    logic signed [DIFF_W-1:0]   diff_reg, diff_next;
    logic [DIFF_W-1:0]          best_d_reg, best_d_next;
    logic signed [M2_W-1:0]     best_a_reg, best_a_next;
    logic signed [M2_W-1:0]     best_b_reg, best_b_next;
    logic                       sel_reg, sel_next;
    logic [SQ_W-1:0]            rad_reg, rad_next;
    logic [REM_W-1:0]           rem_reg, rem_next;
    logic [SUM_W-1:0]           root_reg, root_next;
    logic [ITER_W-1:0]          iter_reg, iter_next;
    logic [MASS_W-1:0]          res_mass_reg, res_mass_next;
    logic [STATUS_W-1:0]        res_status_reg, res_status_next;
    logic                       res_last_reg, res_last_next;
    logic signed [WEIGHT_W-1:0] res_weight_reg, res_weight_next;
    logic [OUT_TRIALS_W-1:0]    res_trials_reg, res_trials_next;
    logic                       out_valid_reg, out_valid_next;
    logic [MASS_W-1:0]          pair_mass_reg, pair_mass_next;
    logic signed [WEIGHT_W-1:0] out_weight_reg, out_weight_next;
    logic [OUT_TRIALS_W-1:0]    out_trials_reg, out_trials_next;
    logic [STATUS_W-1:0]        status_reg, status_next;
    logic                       last_result_reg, last_result_next;

    // combinational helpers
    logic                          in_acc;
    logic [CNT_W-1:0]              cnt_inc;
    logic signed [MOMENTUM_BITS-1:0] mom_a, mom_b;
    logic signed [SUM_W-1:0]       msum;
    logic [SUM_W-1:0]              esum;
    logic [SUM_W-1:0]              abs_sum;
    logic signed [M2_W-1:0]        sq_ext;
    logic [DIFF_W-1:0]             abs_d;
    logic signed [M2_W-1:0]        root_val;
    logic [REM_W-1:0]              rem_sh;
    logic [REM_W-1:0]              trial;
    logic [SUM_W-1:0]              root_step;
    logic [MASS_W-1:0]             mass_sat;
    logic                          out_free;

    // handshake
    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // store write and pair read addresses
    assign wr_en      = in_acc && (count_reg < CNT_FULL);
    assign wr_addr    = count_reg[IDX_W-1:0];
    assign wr_part.e  = MOMENTUM_BITS'(energy);
    assign wr_part.px = MOMENTUM_BITS'(mom_x);
    assign wr_part.py = MOMENTUM_BITS'(mom_y);
    assign wr_part.pz = MOMENTUM_BITS'(mom_z);
    assign rd_addr    = (state_reg == ST_RD_A) ? pair_first(pair_reg)
                                               : pair_second(pair_reg);

    // particle store, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            part_mem[wr_addr] <= wr_part;
        end
        rd_data_reg <= part_mem[rd_addr];
    end

    // saturating particle count
    assign cnt_inc = (count_reg == CNT_SAT) ? count_reg : count_reg + CNT_W'(1);

    // absolute component sum of the current pair
    always_comb
    begin
        case (comp_reg)
            COMP_X:
            begin
                mom_a = pa_reg.px;
                mom_b = rd_data_reg.px;
            end
            COMP_Y:
            begin
                mom_a = pa_reg.py;
                mom_b = rd_data_reg.py;
            end
            default:
            begin
                mom_a = pa_reg.pz;
                mom_b = rd_data_reg.pz;
            end
        endcase
    end

    assign esum    = SUM_W'(pa_reg.e) + SUM_W'(rd_data_reg.e);
    assign msum    = SUM_W'(mom_a) + SUM_W'(mom_b);
    assign abs_sum = (comp_reg == COMP_E) ? esum
                   : (msum[SUM_W-1] ? (~msum + SUM_W'(1)) : msum);
    assign sq_ext  = signed'(M2_W'(sq_reg));

    // absolute pairing difference
    assign abs_d = diff_reg[DIFF_W-1] ? (~diff_reg + DIFF_W'(1)) : diff_reg;

    // square root step, one result bit per cycle
    assign root_val  = sel_reg ? best_b_reg : best_a_reg;
    assign rem_sh    = {rem_reg[REM_W-3:0], rad_reg[SQ_W-1 -: 2]};
    assign trial     = REM_W'({root_reg, 2'b01});
    assign root_step = (rem_sh >= trial) ? {root_reg[SUM_W-2:0], 1'b1}
                                         : {root_reg[SUM_W-2:0], 1'b0};
    assign mass_sat  = (CMP_W'(root_step) > CMP_W'(MASS_MAX)) ? MASS_MAX
                                                              : MASS_W'(root_step);

    // sequencer next state
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        pair_next        = pair_reg;
        comp_next        = comp_reg;
        pa_next          = pa_reg;
        sum_next         = sum_reg;
        sq_next          = sq_reg;
        acc_next         = acc_reg;
        a_next           = a_reg;
        diff_next        = diff_reg;
        best_d_next      = best_d_reg;
        best_a_next      = best_a_reg;
        best_b_next      = best_b_reg;
        sel_next         = sel_reg;
        rad_next         = rad_reg;
        rem_next         = rem_reg;
        root_next        = root_reg;
        iter_next        = iter_reg;
        res_mass_next    = res_mass_reg;
        res_status_next  = res_status_reg;
        res_last_next    = res_last_reg;
        res_weight_next  = res_weight_reg;
        res_trials_next  = res_trials_reg;
        out_valid_next   = out_valid_reg && out_stall;
        pair_mass_next   = pair_mass_reg;
        out_weight_next  = out_weight_reg;
        out_trials_next  = out_trials_reg;
        status_next      = status_reg;
        last_result_next = last_result_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    count_next = cnt_inc;
                    if (last_particle)
                    begin
                        count_next = '0;
                        if (cnt_inc != CNT_FULL)
                        begin
                            res_mass_next   = '0;
                            res_status_next = STATUS_BAD_COUNT;
                            res_last_next   = 1'b1;
                            res_weight_next = '0;
                            res_trials_next = {event_trials, 1'b0};
                            state_next      = ST_EMIT;
                        end
                        else
                        begin
                            res_weight_next = event_weight;
                            res_trials_next = OUT_TRIALS_W'(event_trials);
                            pair_next       = '0;
                            state_next      = ST_RD_A;
                        end
                    end
                end
            end

            ST_RD_A:
            begin
                state_next = ST_RD_B;
            end

            ST_RD_B:
            begin
                pa_next    = rd_data_reg;
                comp_next  = '0;
                state_next = ST_SQ;
            end

            // sum, square and accumulate, three steps overlapped
            ST_SQ:
            begin
                sum_next  = abs_sum;
                sq_next   = sum_reg * sum_reg;
                comp_next = comp_reg + COMP_W'(1);
                if (comp_reg >= COMP_ACC0)
                begin
                    acc_next = (comp_reg == COMP_ACC0) ? sq_ext : acc_reg - sq_ext;
                end
                if (comp_reg == COMP_LAST)
                begin
                    if (!pair_reg[0])
                    begin
                        a_next     = acc_next;
                        pair_next  = pair_reg + PAIR_W'(1);
                        state_next = ST_RD_A;
                    end
                    else
                    begin
                        state_next = ST_DIFF;
                    end
                end
            end

            ST_DIFF:
            begin
                diff_next  = DIFF_W'(a_reg) - DIFF_W'(acc_reg);
                state_next = ST_CMP;
            end

            // a later pairing wins ties against an earlier one
            ST_CMP:
            begin
                if ((pair_reg == PAIR_FIRST_B) || (abs_d <= best_d_reg))
                begin
                    best_d_next = abs_d;
                    best_a_next = a_reg;
                    best_b_next = acc_reg;
                end
                if (pair_reg == PAIR_LAST)
                begin
                    sel_next   = 1'b0;
                    state_next = ST_ROOT_START;
                end
                else
                begin
                    pair_next  = pair_reg + PAIR_W'(1);
                    state_next = ST_RD_A;
                end
            end

            ST_ROOT_START:
            begin
                res_last_next = sel_reg;
                if (root_val[M2_W-1])
                begin
                    res_mass_next   = '0;
                    res_status_next = STATUS_NEG_M2;
                    state_next      = ST_EMIT;
                end
                else
                begin
                    rad_next   = root_val[SQ_W-1:0];
                    rem_next   = '0;
                    root_next  = '0;
                    iter_next  = ITER_W'(SUM_W - 1);
                    state_next = ST_ROOT;
                end
            end

            ST_ROOT:
            begin
                rem_next  = (rem_sh >= trial) ? rem_sh - trial : rem_sh;
                root_next = root_step;
                rad_next  = {rad_reg[SQ_W-3:0], 2'b00};
                iter_next = iter_reg - ITER_W'(1);
                if (iter_reg == '0)
                begin
                    res_mass_next   = mass_sat;
                    res_status_next = STATUS_OK;
                    state_next      = ST_EMIT;
                end
            end

            // hand the result to the output register once it is free
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    pair_mass_next   = res_mass_reg;
                    out_weight_next  = res_weight_reg;
                    out_trials_next  = res_trials_reg;
                    status_next      = res_status_reg;
                    last_result_next = res_last_reg;
                    if (res_last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        sel_next   = 1'b1;
                        state_next = ST_ROOT_START;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            pair_reg        <= '0;
            comp_reg        <= '0;
            pa_reg          <= '0;
            sum_reg         <= '0;
            sq_reg          <= '0;
            acc_reg         <= '0;
            a_reg           <= '0;
            diff_reg        <= '0;
            best_d_reg      <= '0;
            best_a_reg      <= '0;
            best_b_reg      <= '0;
            sel_reg         <= 1'b0;
            rad_reg         <= '0;
            rem_reg         <= '0;
            root_reg        <= '0;
            iter_reg        <= '0;
            res_mass_reg    <= '0;
            res_status_reg  <= STATUS_OK;
            res_last_reg    <= 1'b0;
            res_weight_reg  <= '0;
            res_trials_reg  <= '0;
            out_valid_reg   <= 1'b0;
            pair_mass_reg   <= '0;
            out_weight_reg  <= '0;
            out_trials_reg  <= '0;
            status_reg      <= STATUS_OK;
            last_result_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            pair_reg        <= pair_next;
            comp_reg        <= comp_next;
            pa_reg          <= pa_next;
            sum_reg         <= sum_next;
            sq_reg          <= sq_next;
            acc_reg         <= acc_next;
            a_reg           <= a_next;
            diff_reg        <= diff_next;
            best_d_reg      <= best_d_next;
            best_a_reg      <= best_a_next;
            best_b_reg      <= best_b_next;
            sel_reg         <= sel_next;
            rad_reg         <= rad_next;
            rem_reg         <= rem_next;
            root_reg        <= root_next;
            iter_reg        <= iter_next;
            res_mass_reg    <= res_mass_next;
            res_status_reg  <= res_status_next;
            res_last_reg    <= res_last_next;
            res_weight_reg  <= res_weight_next;
            res_trials_reg  <= res_trials_next;
            out_valid_reg   <= out_valid_next;
            pair_mass_reg   <= pair_mass_next;
            out_weight_reg  <= out_weight_next;
            out_trials_reg  <= out_trials_next;
            status_reg      <= status_next;
            last_result_reg <= last_result_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pair_mass   = pair_mass_reg;
    assign out_weight  = out_weight_reg;
    assign out_trials  = out_trials_reg;
    assign status      = status_reg;
    assign last_result = last_result_reg;

    // closing particle always starts event processing
    a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_particle |=> in_stall)
        else $error("last particle did not block the input");

    // a bad count result is a single, empty entry
    a_bad_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_BAD_COUNT)
        |-> (pair_mass == '0) && (out_weight == '0) && last_result)
        else $error("bad count result not empty or not final");

    // clamped mass squared gives zero mass
    a_neg_m2: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_NEG_M2) |-> (pair_mass == '0))
        else $error("negative mass squared with non-zero mass");

    // the count is cleared whenever an event is being worked on
    a_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (count_reg == '0))
        else $error("particle count not cleared during event processing");

    // pair slot counter stays within the six pairs
    a_pair_range: assert property (@(posedge clk) disable iff (!rst_n)
        pair_reg <= PAIR_LAST)
        else $error("pair slot counter out of range");

endmodule

`default_nettype wire
